// File: hw/rtl/tmcpg_pkg.sv
`default_nettype none

package tmcpg_pkg;

  // field widths
  localparam int unsigned COLS_W   = 7;
  localparam int unsigned ROWS_W   = 6;
  localparam int unsigned DIM_W    = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLOUR_W = 16;

  // reciprocal scaling: rcp = floor(2^RCP_SHIFT / cell_size)
  localparam int unsigned RCP_SHIFT = 10;
  localparam int unsigned DIV_W     = RCP_SHIFT + 1;
  localparam logic [DIV_W-1:0] RCP_ONE = DIV_W'(1) << RCP_SHIFT;

  // result queue depth, also the limit on items in flight
  localparam int unsigned FIFO_DEPTH = 16;

  // register reset values
  localparam logic [COLS_W-1:0] COLS_RST   = 7'd80;
  localparam logic [ROWS_W-1:0] ROWS_RST   = 6'd25;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 10'd240;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 10'd320;

  // printable character range
  localparam logic [BYTE_W-1:0] CHR_FIRST = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_LAST  = 8'h7E;

  typedef enum logic [1:0] {
    REQ_VIDEO = 2'd0,
    REQ_FONT  = 2'd1,
    REQ_PIXEL = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_START_CW,
    ST_WAIT_CW,
    ST_START_CH,
    ST_WAIT_CH,
    ST_START_RW,
    ST_WAIT_RW,
    ST_START_RH,
    ST_WAIT_RH,
    ST_RUN
  } ctl_state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

  // rgb565 palette
  function automatic logic [COLOUR_W-1:0] palette565(input logic [3:0] idx);
    logic [COLOUR_W-1:0] c;
    unique case (idx)
      4'd0:  c = 16'h0000;
      4'd1:  c = 16'h0015;
      4'd2:  c = 16'h0540;
      4'd3:  c = 16'h0555;
      4'd4:  c = 16'hA800;
      4'd5:  c = 16'hA815;
      4'd6:  c = 16'hAAA0;
      4'd7:  c = 16'hAD55;
      4'd8:  c = 16'h5AAB;
      4'd9:  c = 16'h555F;
      4'd10: c = 16'h57E0;
      4'd11: c = 16'h57FF;
      4'd12: c = 16'hF800;
      4'd13: c = 16'hF81F;
      4'd14: c = 16'hFFE0;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

  // font content after reset: glyph one is the exclamation mark
  function automatic logic [BYTE_W-1:0] font_reset_byte(input logic [10:0] addr);
    logic [BYTE_W-1:0] b;
    unique case (addr[2:0])
      3'd0: b = 8'h18;
      3'd1: b = 8'h3C;
      3'd2: b = 8'h3C;
      3'd3: b = 8'h18;
      3'd4: b = 8'h18;
      3'd5: b = 8'h00;
      3'd6: b = 8'h18;
      default: b = 8'h00;
    endcase
    return (addr[10:3] == 8'd1) ? b : 8'h00;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tmcpg_ram.sv
`default_nettype none

module tmcpg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire  [$clog2(DEPTH)-1:0]        waddr_i,
  input  wire  [WIDTH-1:0]                wdata_i,
  input  wire                             re_i,
  input  wire  [$clog2(DEPTH)-1:0]        raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tmcpg_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module tmcpg_div
  import tmcpg_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  div_req_t   req_i,
  output div_stat_t  stat_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [DIM_W-1:0] dvs_q, dvs_d;
  logic [DIM_W:0]   rem_sh;

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DIV_W);
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = DIM_W'(rem_sh - {1'b0, dvs_q});
          quo_d = {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DIM_W-1:0];
          quo_d = {quo_q[DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done     = run_q && (cnt_q == '0);
  assign stat_o.quotient = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/text_mode_cell_pixel_generator_core.sv
`default_nettype none

// Text-mode pixel generator. Input items write a video byte (character at even
// address, attribute at odd), write a font byte (glyph*8+row, glyphs from code 0x20),
// or request one output pixel. A pixel request returns one item with the RGB565
// colour and a covered flag; writes return nothing. Sustained rate is one item per
// clock; a pixel result passes through a seven stage pipeline: reciprocal multiply,
// multiply back, remainder correction, cell index and glyph scaling, video read, font
// read, palette. Video and font writes are applied at the same stage as the matching
// reads, so stores and loads stay in item order without forwarding. Cell width and
// height and their reciprocals are worked out by a shared serial divider after reset
// and after every register write; tready stays low meanwhile. After reset the font
// store is first loaded with its default content, one byte a cycle. VIDEO_BYTES must
// be a power of two. Up to 16 items may be in flight; results queue in a 16-entry
// buffer, so a stalled output side does not stop input until the items in flight,
// queued results included, reach 16.
module text_mode_cell_pixel_generator_core
  import tmcpg_pkg::*;
#(
  parameter int unsigned VIDEO_BYTES = 4096,
  parameter int unsigned GLYPH_COUNT = 96
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration writes
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [CFG_W-1:0]    cfg_data_i,
  // input items
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // write_address, write_data, pixel_x, pixel_y
  input  wire  [39:0]         s_axis_tdata,
  // req_type
  input  wire  [1:0]          s_axis_tuser,
  // result items
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // pixel_colour
  output logic [15:0]         m_axis_tdata,
  // covered
  output logic [0:0]          m_axis_tuser
);

  localparam int unsigned FONT_BYTES = GLYPH_COUNT * 8;
  localparam int unsigned FAW        = $clog2(FONT_BYTES);
  localparam int unsigned HALF_BYTES = VIDEO_BYTES / 2;
  localparam int unsigned VAW        = $clog2(HALF_BYTES);
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= COLS_RST;
      rows_q   <= ROWS_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_COLUMNS: cols_q   <= cfg_data_i[COLS_W-1:0];
        CFG_ROWS:    rows_q   <= cfg_data_i[ROWS_W-1:0];
        CFG_WIDTH:   width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // control: font load after reset, then cell size and reciprocal divisions
  // ---------------------------------------------------------------------------
  ctl_state_e        state_q, state_d;
  logic [FAW-1:0]    clr_q;
  logic              clr_last;
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic              ld_cw, ld_ch, ld_rw, ld_rh;

  // derived geometry, stable while items flow
  logic [DIM_W-1:0]  cw_q, ch_q;
  logic [DIV_W-1:0]  rw_q, rh_q;
  logic [12:0]       thr_w_q [1:7];
  logic [12:0]       thr_h_q [1:7];

  assign clr_last = (clr_q == FAW'(FONT_BYTES - 1));

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(width_q);
    div_req.divisor  = DIM_W'(cols_q);
    ld_cw            = 1'b0;
    ld_ch            = 1'b0;
    ld_rw            = 1'b0;
    ld_rh            = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_START_CW;
        end
      end
      ST_START_CW: begin
        div_req.start = 1'b1;
        state_d       = ST_WAIT_CW;
      end
      ST_WAIT_CW: begin
        if (div_stat.done) begin
          ld_cw   = 1'b1;
          state_d = ST_START_CH;
        end
      end
      ST_START_CH: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(height_q);
        div_req.divisor  = DIM_W'(rows_q);
        state_d          = ST_WAIT_CH;
      end
      ST_WAIT_CH: begin
        if (div_stat.done) begin
          ld_ch   = 1'b1;
          state_d = ST_START_RW;
        end
      end
      ST_START_RW: begin
        div_req.start    = 1'b1;
        div_req.dividend = RCP_ONE;
        div_req.divisor  = cw_q;
        state_d          = ST_WAIT_RW;
      end
      ST_WAIT_RW: begin
        if (div_stat.done) begin
          ld_rw   = 1'b1;
          state_d = ST_START_RH;
        end
      end
      ST_START_RH: begin
        div_req.start    = 1'b1;
        div_req.dividend = RCP_ONE;
        div_req.divisor  = ch_q;
        state_d          = ST_WAIT_RH;
      end
      ST_WAIT_RH: begin
        if (div_stat.done) begin
          ld_rh   = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_d = ST_CLEAR;
    endcase
    // any register change restarts the geometry work
    if (cfg_we_i && (state_q != ST_CLEAR)) begin
      state_d = ST_START_CW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_cw) cw_q <= div_stat.quotient[DIM_W-1:0];
    if (ld_ch) ch_q <= div_stat.quotient[DIM_W-1:0];
    if (ld_rw) rw_q <= div_stat.quotient;
    if (ld_rh) rh_q <= div_stat.quotient;
    // glyph scaling thresholds k*cell_size
    for (int k = 1; k <= 7; k++) begin
      thr_w_q[k] <= 13'(k * int'(cw_q));
      thr_h_q[k] <= 13'(k * int'(ch_q));
    end
  end

  tmcpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

  // ---------------------------------------------------------------------------
  // flow control: credit for every item in flight plus queued results
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic [CNT_W-1:0]  inflight_q, inflight_d;
  logic              fifo_push, fifo_pop, drop;

  assign s_axis_tready = (state_q == ST_RUN) && (inflight_q < CNT_W'(FIFO_DEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    inflight_d = inflight_q + CNT_W'(in_acc) - CNT_W'(fifo_pop) - CNT_W'(drop);
  end

  // ---------------------------------------------------------------------------
  // pixel pipeline
  // ---------------------------------------------------------------------------
  logic              v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [1:0]        t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;
  logic [ADDR_W-1:0] a1_q, a2_q, a3_q, a4_q, a5_q, a6_q;
  logic [BYTE_W-1:0] d1_q, d2_q, d3_q, d4_q, d5_q, d6_q;
  logic [DIM_W-1:0]  x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;

  // stage 1: reciprocal multiply and plain range checks
  logic [20:0]       prod_x, prod_y;
  logic              bad1;
  logic [20:0]       px2_q, py2_q;
  logic              bad2_q;

  assign prod_x = 21'(x1_q) * 21'(rw_q);
  assign prod_y = 21'(y1_q) * 21'(rh_q);
  assign bad1   = (cols_q == '0) || (rows_q == '0) || (cw_q == '0) || (ch_q == '0) ||
                  (x1_q >= width_q) || (y1_q >= height_q);

  // stage 2: estimate quotient, multiply back
  logic [DIV_W-1:0]  qx_est, qy_est;
  logic [DIV_W-1:0]  qx3_q, qy3_q;
  logic [20:0]       mx3_q, my3_q;
  logic              bad3_q;

  assign qx_est = px2_q[20:RCP_SHIFT];
  assign qy_est = py2_q[20:RCP_SHIFT];

  // stage 3: estimate is exact or one low; one compare and subtract fixes it
  logic [DIV_W-1:0]  rx, ry;
  logic              fix_x, fix_y;
  logic [DIV_W-1:0]  col, row;
  logic [DIM_W-1:0]  offs_x, offs_y;
  logic              bad3;
  logic [DIV_W-1:0]  col4_q, row4_q;
  logic [DIM_W-1:0]  ox4_q, oy4_q;
  logic              bad4_q;

  always_comb begin
    rx     = {1'b0, x3_q} - mx3_q[DIV_W-1:0];
    ry     = {1'b0, y3_q} - my3_q[DIV_W-1:0];
    fix_x  = rx >= {1'b0, cw_q};
    fix_y  = ry >= {1'b0, ch_q};
    col    = fix_x ? qx3_q + 1'b1 : qx3_q;
    row    = fix_y ? qy3_q + 1'b1 : qy3_q;
    offs_x = fix_x ? DIM_W'(rx - {1'b0, cw_q}) : rx[DIM_W-1:0];
    offs_y = fix_y ? DIM_W'(ry - {1'b0, ch_q}) : ry[DIM_W-1:0];
    bad3   = bad3_q || (col >= DIV_W'(cols_q)) || (row >= DIV_W'(rows_q));
  end

  // stage 4: cell index and nearest-neighbour glyph coordinates
  logic [13:0]       cell_idx;
  logic [31:0]       cell_ext;
  logic [12:0]       ox8, oy8;
  logic [2:0]        gx, gy;
  logic [VAW-1:0]    pair5_q;
  logic [2:0]        gx5_q, gy5_q, gx6_q, gy6_q, gx7_q;
  logic              bad5_q, bad6_q, bad7_q;

  always_comb begin
    cell_idx = 14'(row4_q[ROWS_W-1:0]) * 14'(cols_q) + 14'(col4_q[COLS_W-1:0]);
    cell_ext = 32'(cell_idx);
    ox8      = {ox4_q, 3'b000};
    oy8      = {oy4_q, 3'b000};
    gx       = '0;
    gy       = '0;
    for (int k = 1; k <= 7; k++) begin
      gx = gx + 3'(ox8 >= thr_w_q[k]);
      gy = gy + 3'(oy8 >= thr_h_q[k]);
    end
  end

  // stage 5: video memory, character bank and attribute bank
  logic [31:0]       a5_ext;
  logic [VAW-1:0]    vid_widx;
  logic              vid_wr, vid_rd;
  logic [BYTE_W-1:0] chr_rdata, attr_rdata;

  assign a5_ext   = 32'(a5_q);
  assign vid_widx = a5_ext[VAW:1];
  assign vid_wr   = v5_q && (t5_q == REQ_VIDEO);
  assign vid_rd   = v5_q && (t5_q == REQ_PIXEL);

  tmcpg_ram #(.WIDTH(BYTE_W), .DEPTH(HALF_BYTES)) u_chr_ram (
    .clk_i   (clk_i),
    .we_i    (vid_wr && !a5_q[0]),
    .waddr_i (vid_widx),
    .wdata_i (d5_q),
    .re_i    (vid_rd),
    .raddr_i (pair5_q),
    .rdata_o (chr_rdata)
  );

  tmcpg_ram #(.WIDTH(BYTE_W), .DEPTH(HALF_BYTES)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (vid_wr && a5_q[0]),
    .waddr_i (vid_widx),
    .wdata_i (d5_q),
    .re_i    (vid_rd),
    .raddr_i (pair5_q),
    .rdata_o (attr_rdata)
  );

  // stage 6: glyph select and font store
  logic [6:0]        glyph;
  logic [31:0]       fnt_rd_ext;
  logic [31:0]       a6_ext;
  logic              fnt_wr;
  logic              fnt_we;
  logic [FAW-1:0]    fnt_waddr;
  logic [BYTE_W-1:0] fnt_wdata;
  logic [BYTE_W-1:0] fnt_rdata;
  logic [BYTE_W-1:0] attr7_q;

  always_comb begin
    glyph      = ((chr_rdata >= CHR_FIRST) && (chr_rdata <= CHR_LAST)) ?
                 7'(chr_rdata - CHR_FIRST) : 7'd0;
    fnt_rd_ext = 32'({glyph, gy6_q});
    a6_ext     = 32'(a6_q);
    fnt_wr     = v6_q && (t6_q == REQ_FONT) && (a6_ext < 32'(FONT_BYTES));
    // the load after reset owns the write port while no item is accepted
    if (state_q == ST_CLEAR) begin
      fnt_we    = 1'b1;
      fnt_waddr = clr_q;
      fnt_wdata = font_reset_byte(11'(clr_q));
    end else begin
      fnt_we    = fnt_wr;
      fnt_waddr = a6_ext[FAW-1:0];
      fnt_wdata = d6_q;
    end
  end

  tmcpg_ram #(.WIDTH(BYTE_W), .DEPTH(FONT_BYTES)) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (fnt_we),
    .waddr_i (fnt_waddr),
    .wdata_i (fnt_wdata),
    .re_i    (v6_q && (t6_q == REQ_PIXEL)),
    .raddr_i (fnt_rd_ext[FAW-1:0]),
    .rdata_o (fnt_rdata)
  );

  // stage 7: pick glyph bit (msb is leftmost) and palette entry
  logic              fg;
  logic [COLOUR_W-1:0] colour;

  always_comb begin
    fg = fnt_rdata[3'd7 - gx7_q];
    if (bad7_q) begin
      colour = '0;
    end else if (fg) begin
      colour = palette565(attr7_q[3:0]);
    end else begin
      colour = palette565(attr7_q[7:4]);
    end
  end

  assign fifo_push = v7_q && (t7_q == REQ_PIXEL);
  assign drop      = v7_q && (t7_q != REQ_PIXEL);

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
      v6_q       <= 1'b0;
      v7_q       <= 1'b0;
      inflight_q <= '0;
    end else begin
      v1_q       <= in_acc;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      v5_q       <= v4_q;
      v6_q       <= v5_q;
      v7_q       <= v6_q;
      inflight_q <= inflight_d;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    t1_q <= s_axis_tuser;
    a1_q <= s_axis_tdata[11:0];
    d1_q <= s_axis_tdata[19:12];
    x1_q <= s_axis_tdata[29:20];
    y1_q <= s_axis_tdata[39:30];

    t2_q   <= t1_q;
    a2_q   <= a1_q;
    d2_q   <= d1_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    px2_q  <= prod_x;
    py2_q  <= prod_y;
    bad2_q <= bad1;

    t3_q   <= t2_q;
    a3_q   <= a2_q;
    d3_q   <= d2_q;
    x3_q   <= x2_q;
    y3_q   <= y2_q;
    qx3_q  <= qx_est;
    qy3_q  <= qy_est;
    bad3_q <= bad2_q;
    mx3_q  <= 21'(qx_est) * 21'(cw_q);
    my3_q  <= 21'(qy_est) * 21'(ch_q);

    t4_q   <= t3_q;
    a4_q   <= a3_q;
    d4_q   <= d3_q;
    col4_q <= col;
    row4_q <= row;
    ox4_q  <= offs_x;
    oy4_q  <= offs_y;
    bad4_q <= bad3;

    t5_q    <= t4_q;
    a5_q    <= a4_q;
    d5_q    <= d4_q;
    pair5_q <= cell_ext[VAW-1:0];
    gx5_q   <= gx;
    gy5_q   <= gy;
    bad5_q  <= bad4_q;

    t6_q   <= t5_q;
    a6_q   <= a5_q;
    d6_q   <= d5_q;
    gx6_q  <= gx5_q;
    gy6_q  <= gy5_q;
    bad6_q <= bad5_q;

    t7_q    <= t6_q;
    gx7_q   <= gx6_q;
    bad7_q  <= bad6_q;
    attr7_q <= attr_rdata;
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  logic [COLOUR_W:0] fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  fcnt_q;

  assign m_axis_tvalid   = (fcnt_q != '0);
  assign fifo_pop        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata    = fifo_q[rd_ptr_q][COLOUR_W-1:0];
  assign m_axis_tuser[0] = fifo_q[rd_ptr_q][COLOUR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      if (fifo_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (fifo_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      fcnt_q <= fcnt_q + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= {!bad7_q, colour};
    end
  end

`ifndef SYNTHESIS
  // queued results are always covered by outstanding credit
  a_fifo_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= inflight_q)
    else $error("result queue holds more than the items in flight");

  // nothing enters while the font store is being loaded
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!s_axis_tready && !v6_q))
    else $error("item accepted during font load");

  // an uncovered pixel reports colour zero
  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("uncovered pixel with nonzero colour");

  // a pixel item reaching the end produces a queue entry on the next cycle
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_push && !fifo_pop) |=> (fcnt_q == $past(fcnt_q) + 1'b1))
    else $error("result lost on push");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_text_mode_cell_pixel_generator_core.sv
`default_nettype none

module tb_text_mode_cell_pixel_generator_core;
  import tmcpg_pkg::*;

  localparam int unsigned VIDEO_BYTES = 4096;
  localparam int unsigned GLYPH_COUNT = 96;
  localparam int unsigned FONT_BYTES  = GLYPH_COUNT * 8;

  // request kind that the block drops without a result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // margin for writes still in flight after the last pixel
  localparam int unsigned SETTLE_CYCLES = 24;
  // long output hold-off so the result buffer fills and input backs up
  localparam int unsigned STALL_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS   = 130;

  localparam logic [15:0] RGB565 [16] = '{
    16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'hA800, 16'hA815, 16'hAAA0, 16'hAD55,
    16'h5AAB, 16'h555F, 16'h57E0, 16'h57FF, 16'hF800, 16'hF81F, 16'hFFE0, 16'hFFFF
  };

  localparam logic [7:0] BANG_ROWS [8] = '{
    8'h18, 8'h3C, 8'h3C, 8'h18, 8'h18, 8'h00, 8'h18, 8'h00
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [9:0]  x;
    logic [9:0]  y;
  } text_req_t;

  typedef struct packed {
    logic [15:0] colour;
    logic        covered;
  } pixel_result_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = CFG_COLUMNS;
  logic [9:0]  cfg_data_i  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // write_address [11:0], write_data [19:12], pixel_x [29:20], pixel_y [39:30]
  logic [39:0] s_axis_tdata  = '0;
  // req_type [1:0]
  logic [1:0]  s_axis_tuser  = '0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pixel_colour [15:0]
  logic [15:0] m_axis_tdata;
  // covered [0]
  logic [0:0]  m_axis_tuser;

  text_mode_cell_pixel_generator_core #(
    .VIDEO_BYTES (VIDEO_BYTES),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block's registers and stores; the stores are updated on accepted items
  int unsigned   grid_cols   = COLS_RST;
  int unsigned   grid_rows   = ROWS_RST;
  int unsigned   scr_width   = WIDTH_RST;
  int unsigned   scr_height  = HEIGHT_RST;
  logic [7:0]    video_shadow [VIDEO_BYTES];
  logic [7:0]    font_shadow  [FONT_BYTES];

  // video bytes already queued for writing; pixel requests only read these
  bit            video_written [VIDEO_BYTES];

  text_req_t     request_queue[$];
  pixel_result_t expected_pixels[$];
  text_req_t     offered_item;

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   stall_orders  = 0;
  int unsigned   stall_served  = 0;
  int unsigned   stall_left    = 0;
  int unsigned   failures      = 0;

  // cell lookup: covered flag, character address and glyph bit position
  function automatic bit locate_cell(input int unsigned x, input int unsigned y,
                                     output logic [11:0] chr_addr,
                                     output logic [2:0] gx, output logic [2:0] gy);
    int unsigned cw, ch, col, row, px, py, cell_idx;
    chr_addr = '0;
    gx = '0;
    gy = '0;
    if (grid_cols == 0 || grid_rows == 0) return 1'b0;
    cw = scr_width / grid_cols;
    ch = scr_height / grid_rows;
    if (cw == 0 || ch == 0 || x >= scr_width || y >= scr_height) return 1'b0;
    col = x / cw;
    row = y / ch;
    if (col >= grid_cols || row >= grid_rows) return 1'b0;
    px = x - col * cw;
    py = y - row * ch;
    cell_idx = row * grid_cols + col;
    // video address wraps at the memory size
    chr_addr = 12'((cell_idx * 2) % VIDEO_BYTES);
    gx = 3'((px * 8) / cw);
    gy = 3'((py * 8) / ch);
    return 1'b1;
  endfunction

  // apply one accepted item to the shadow state, queue its pixel if any
  task automatic render_item(input text_req_t it);
    logic [11:0]   chr_addr;
    logic [2:0]    gx, gy;
    logic [7:0]    chr, attr, glyph_row;
    int unsigned   glyph;
    pixel_result_t res;
    case (it.kind)
      REQ_VIDEO: video_shadow[it.addr] = it.data;
      REQ_FONT: begin
        // font writes past the last glyph are dropped
        if (it.addr < FONT_BYTES) font_shadow[it.addr] = it.data;
      end
      REQ_PIXEL: begin
        res = '0;
        if (locate_cell(it.x, it.y, chr_addr, gx, gy)) begin
          chr  = video_shadow[chr_addr];
          attr = video_shadow[chr_addr + 12'd1];
          // non-printable characters fall back to glyph zero
          glyph = (chr >= CHR_FIRST && chr <= CHR_LAST) ? int'(chr - CHR_FIRST) : 0;
          glyph_row = font_shadow[glyph * 8 + gy];
          res.covered = 1'b1;
          // msb is the leftmost pixel; fg in low nibble, bg in high nibble
          res.colour = glyph_row[7 - gx] ? RGB565[attr[3:0]] : RGB565[attr[7:4]];
        end
        expected_pixels.push_back(res);
      end
      default: ;
    endcase
  endtask

  // sender: offers queued items, predicts each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        render_item(offered_item);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_item = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered_item.y, offered_item.x, offered_item.data,
                            offered_item.addr};
          s_axis_tuser  <= offered_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_colour %h covered %0d",
                 m_axis_tdata, m_axis_tuser[0]);
          failures++;
        end else begin
          exp_res = expected_pixels.pop_front();
          if (m_axis_tdata !== exp_res.colour) begin
            $error("pixel_colour: expected %h, got %h", exp_res.colour, m_axis_tdata);
            failures++;
          end
          if (m_axis_tuser[0] !== exp_res.covered) begin
            $error("covered: expected %0d, got %0d", exp_res.covered, m_axis_tuser[0]);
            failures++;
          end
        end
      end
      // a new hold-off order starts a long stretch of tready low
      if (stall_orders != stall_served) begin
        stall_served = stall_orders;
        stall_left   = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_item(input logic [1:0] kind, input logic [11:0] addr,
                            input logic [7:0] data, input logic [9:0] x,
                            input logic [9:0] y);
    text_req_t it;
    it.kind = kind;
    it.addr = addr;
    it.data = data;
    it.x    = x;
    it.y    = y;
    if (kind == REQ_VIDEO) video_written[addr] = 1'b1;
    request_queue.push_back(it);
  endtask

  // mostly printable characters so the font content shows up
  function automatic logic [7:0] random_char();
    return ($urandom_range(3) != 0) ? 8'($urandom_range(CHR_LAST, CHR_FIRST))
                                    : 8'($urandom);
  endfunction

  // pixel request; first fills in any video byte of its cell not yet written
  task automatic queue_pixel(input int unsigned x, input int unsigned y);
    logic [11:0] chr_addr;
    logic [2:0]  gx, gy;
    if (locate_cell(x, y, chr_addr, gx, gy)) begin
      if (!video_written[chr_addr])
        queue_item(REQ_VIDEO, chr_addr, random_char(), 10'($urandom), 10'($urandom));
      if (!video_written[chr_addr + 12'd1])
        queue_item(REQ_VIDEO, chr_addr + 12'd1, 8'($urandom), 10'($urandom),
                   10'($urandom));
    end
    queue_item(REQ_PIXEL, 12'($urandom), 8'($urandom), 10'(x), 10'(y));
  endtask

  // coordinate mostly on screen, sometimes anywhere in the field range
  function automatic int unsigned random_coord(input int unsigned limit);
    return ($urandom_range(4) != 0) ? $urandom_range(limit - 1) : $urandom_range(1023);
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_pixel(random_coord(scr_width), random_coord(scr_height));
      end else if (pick < 70) begin
        queue_item(REQ_VIDEO, 12'($urandom), random_char(), 10'($urandom),
                   10'($urandom));
      end else if (pick < 95) begin
        // font writes mostly in range, a few past the last glyph
        queue_item(REQ_FONT,
                   ($urandom_range(6) != 0) ? 12'($urandom_range(FONT_BYTES - 1))
                                            : 12'($urandom),
                   8'($urandom), 10'($urandom), 10'($urandom));
      end else begin
        queue_item(REQ_UNUSED, 12'($urandom), 8'($urandom), 10'($urandom),
                   10'($urandom));
      end
    end
  endtask

  // block until every item is accepted and every pixel has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 10'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned cols, input int unsigned rows,
                           input int unsigned width, input int unsigned height,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input bit hold_off);
    wait_idle();
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_HEIGHT, height);
    grid_cols  = cols;
    grid_rows  = rows;
    scr_width  = width;
    scr_height = height;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (hold_off) stall_orders++;
    queue_random(PHASE_ITEMS);
  endtask

  initial begin
    // font content after reset: only the exclamation mark glyph is set
    for (int i = 0; i < FONT_BYTES; i++) font_shadow[i] = 8'h00;
    for (int i = 0; i < 8; i++) font_shadow[8 + i] = BANG_ROWS[i];

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles often, receiver even more
    send_idle_pct = 34;
    recv_idle_pct = 79;

    // directed part at the reset geometry: 3x12 pixel cells, 80x25 grid
    queue_item(REQ_FONT, 12'd0, 8'h81, 10'h3FF, 10'h000);
    queue_item(REQ_FONT, 12'(FONT_BYTES - 1), 8'hA5, 10'h000, 10'h3FF);
    queue_item(REQ_FONT, 12'(FONT_BYTES), 8'hFF, 10'h155, 10'h2AA);
    queue_item(REQ_FONT, 12'hFFF, 8'hFF, 10'h2AA, 10'h155);
    queue_item(REQ_VIDEO, 12'd0, 8'h21, 10'h000, 10'h000);
    queue_item(REQ_VIDEO, 12'd1, 8'h1E, 10'h000, 10'h000);
    queue_pixel(0, 0);
    queue_pixel(1, 2);
    // characters just past each end of the printable range, then the last printable one
    queue_item(REQ_VIDEO, 12'd2, 8'h7F, 10'h000, 10'h000);
    queue_item(REQ_VIDEO, 12'd3, 8'hF0, 10'h000, 10'h000);
    queue_pixel(3, 0);
    queue_item(REQ_VIDEO, 12'd4, 8'h1F, 10'h000, 10'h000);
    queue_item(REQ_VIDEO, 12'd5, 8'h0F, 10'h000, 10'h000);
    queue_pixel(6, 0);
    queue_item(REQ_VIDEO, 12'd6, CHR_LAST, 10'h000, 10'h000);
    queue_item(REQ_VIDEO, 12'd7, 8'h4C, 10'h000, 10'h000);
    queue_pixel(9, 11);
    queue_item(REQ_VIDEO, 12'hFFF, 8'hFF, 10'h3FF, 10'h3FF);
    // last covered pixel, then just outside the grid and the screen
    queue_pixel(239, 299);
    queue_pixel(239, 300);
    queue_pixel(240, 0);
    queue_pixel(1023, 1023);
    queue_item(REQ_UNUSED, 12'hFFF, 8'hFF, 10'h3FF, 10'h3FF);
    queue_item(REQ_UNUSED, 12'h000, 8'h00, 10'h000, 10'h000);

    // output held off for a long stretch while the sender keeps going
    stall_orders++;
    queue_random(PHASE_ITEMS);

    // smallest grid on the largest screen, then largest grid (address wrap)
    run_phase(1, 1, 1023, 1023, 34, 79, 1'b0);
    run_phase(127, 63, 1023, 1023, 34, 79, 1'b0);

    // now the receiver is the faster side
    run_phase(40, 25, 320, 200, 79, 34, 1'b0);
    run_phase(127, 63, 1, 1, 79, 34, 1'b0);
    run_phase(1, 1, 1, 1, 79, 34, 1'b0);

    // no idling at all, the first of these phases with a long output hold-off
    run_phase($urandom_range(127, 1), $urandom_range(63, 1), $urandom_range(1023, 1),
              $urandom_range(1023, 1), 0, 0, 1'b1);
    run_phase($urandom_range(127, 1), $urandom_range(63, 1), $urandom_range(1023, 1),
              $urandom_range(1023, 1), 0, 0, 1'b0);
    run_phase(13, 9, 1000, 517, 0, 0, 1'b0);

    wait_idle();
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard limit on the run, far beyond the slowest correct run
  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
